// ----- design/plr_pkg.sv -----
// Shared constants and elaboration-time helpers for the power-law tone roll-off unit.
`timescale 1ns / 1ps

package plr_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_LEVEL      = 2'd0,
    REG_MAX_LEVEL      = 2'd1,
    REG_TARGET_LEVEL   = 2'd2,
    REG_CURVE_EXPONENT = 2'd3
  } reg_index_t;

  // Register reset values
  localparam logic [31:0] MIN_LEVEL_RST      = 32'd0;
  localparam logic [31:0] MAX_LEVEL_RST      = 32'd655360000;
  localparam logic [31:0] TARGET_LEVEL_RST   = 32'd6553600;
  localparam logic [15:0] CURVE_EXPONENT_RST = 16'd4096;

  // 1.0 in Q1.30 and the Q1.30 clamp level 2.0
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] Q30_TWO = 32'h8000_0000;

  // Saturation limits of the result
  localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

  // Integer square root, used only at elaboration
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = v;
    res   = 64'd0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_w != 64'd0) begin
        if (rem >= res + bit_w) begin
          rem = rem - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // Q1.30 factor 2^(2^-i), built by repeated square roots from 2.0
  function automatic logic [31:0] exp_coef(input int idx);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int j = 1; j <= 32; j++) begin
      if (j <= idx) begin
        c = isqrt64(c << 30);
      end
    end
    return c[31:0];
  endfunction

endpackage

// ----- design/plr_log2.sv -----
// Pipelined log2: leading-one normalize, then one squaring stage per fraction bit.
`timescale 1ns / 1ps

module plr_log2 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          x,
  output logic [FRAC_BITS+4:0] lg
);

  logic [4:0]           k_pipe  [0:FRAC_BITS];
  logic [31:0]          m_pipe  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] fr_pipe [0:FRAC_BITS];

  logic [4:0] k_next;

  // Find the top set bit
  always_comb begin
    k_next = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) k_next = 5'(i);
    end
  end

  // Normalize mantissa to Q1.31
  always_ff @(posedge clk) begin
    if (en) begin
      k_pipe[0]  <= k_next;
      m_pipe[0]  <= x << (5'd31 - k_next);
      fr_pipe[0] <= '0;
    end
  end

  // One fraction bit per stage: square, halve when it reaches 2.0
  for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] sq_s;
    assign sq   = 64'(m_pipe[j-1]) * 64'(m_pipe[j-1]);
    assign sq_s = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        k_pipe[j]  <= k_pipe[j-1];
        m_pipe[j]  <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
        fr_pipe[j] <= {fr_pipe[j-1][FRAC_BITS-2:0], sq_s[32]};
      end
    end
  end

  assign lg = {k_pipe[FRAC_BITS], fr_pipe[FRAC_BITS]};

endmodule

// ----- design/plr_exp2.sv -----
// Pipelined 2^f in Q1.30: one conditional multiply per fraction bit.
`timescale 1ns / 1ps

module plr_exp2 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] f,
  output logic [31:0]          pw
);

  logic [31:0]          m_pipe [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] f_pipe [1:FRAC_BITS];

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_mul
    localparam logic [31:0] COEF = plr_pkg::exp_coef(i);
    logic [31:0]          m_in;
    logic [FRAC_BITS-1:0] f_in;
    logic [63:0]          prod;
    logic [63:0]          scaled;
    logic [31:0]          m_next;

    if (i == 1) begin : g_first
      assign m_in = plr_pkg::Q30_ONE;
      assign f_in = f;
    end else begin : g_rest
      assign m_in = m_pipe[i-1];
      assign f_in = f_pipe[i-1];
    end

    // Multiply by the stage factor with rounding, clamp at 2.0
    assign prod   = 64'(m_in) * 64'(COEF) + (64'd1 << 29);
    assign scaled = prod >> 30;
    always_comb begin
      if (!f_in[FRAC_BITS-i]) m_next = m_in;
      else if (scaled > 64'(plr_pkg::Q30_TWO)) m_next = plr_pkg::Q30_TWO;
      else m_next = scaled[31:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_pipe[i] <= m_next;
        f_pipe[i] <= f_in;
      end
    end
  end

  assign pw = m_pipe[FRAC_BITS];

endmodule

// ----- design/power_law_tone_rolloff_unit.sv -----
// Top level of the power-law tone roll-off unit: config registers and the sample pipeline.
//
//  Port group   Direction  Handshake             Payload
//  in           input      in_valid / in_stall   sample_in
//  out          output     out_valid / out_stall sample_out, saturated
//  cfg          input      cfg_write             cfg_index, cfg_data
//
// One sample enters per clock while in_stall is low; the pipeline depth is set by the log2
// squaring chain and the exp2 multiply chain, one stage per fraction bit each.
// Reset is synchronous and clears the valid bits and loads the register defaults.
// A stall on the output holds the whole pipeline once the output register is full;
// bubbles ahead of it are held as well and do not close up.
`timescale 1ns / 1ps

module power_law_tone_rolloff_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample_out,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NST   = 2 * FRAC_BITS + 6;
  localparam int LOG_W = FRAC_BITS + 5;
  localparam int L_W   = FRAC_BITS + 6;
  localparam int P_W   = FRAC_BITS + 23;
  localparam int Y_W   = FRAC_BITS + 11;

  // Configuration registers
  logic signed [31:0] min_level;
  logic signed [31:0] max_level;
  logic signed [31:0] target_level;
  logic [15:0]        curve_exponent;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level      <= plr_pkg::MIN_LEVEL_RST;
      max_level      <= plr_pkg::MAX_LEVEL_RST;
      target_level   <= plr_pkg::TARGET_LEVEL_RST;
      curve_exponent <= plr_pkg::CURVE_EXPONENT_RST;
    end else if (cfg_write) begin
      unique case (plr_pkg::reg_index_t'(cfg_index))
        plr_pkg::REG_MIN_LEVEL:      min_level      <= cfg_data;
        plr_pkg::REG_MAX_LEVEL:      max_level      <= cfg_data;
        plr_pkg::REG_TARGET_LEVEL:   target_level   <= cfg_data;
        plr_pkg::REG_CURVE_EXPONENT: curve_exponent <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Advance whenever the output register is empty or being taken
  logic en;
  logic v [0:NST-1];

  assign en        = !v[NST-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NST; j++) v[j] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int j = 1; j < NST; j++) v[j] <= v[j-1];
    end
  end

  // Stage 0: offsets from black level and pass-through test
  logic signed [32:0] d_next;
  logic signed [32:0] r_next;
  logic [31:0]        d_reg;
  logic [31:0]        r_reg;
  logic signed [31:0] s_pipe    [0:NST-2];
  logic               pass_pipe [0:NST-2];

  assign d_next = 33'(sample_in) - 33'(min_level);
  assign r_next = 33'(max_level) - 33'(min_level);

  always_ff @(posedge clk) begin
    if (en) begin
      d_reg        <= d_next[31:0];
      r_reg        <= r_next[31:0];
      s_pipe[0]    <= sample_in;
      pass_pipe[0] <= (d_next <= 33'sd0) || (r_next <= 33'sd0);
      for (int j = 1; j < NST - 1; j++) begin
        s_pipe[j]    <= s_pipe[j-1];
        pass_pipe[j] <= pass_pipe[j-1];
      end
    end
  end

  // Log2 of both offsets
  logic [LOG_W-1:0] log_d;
  logic [LOG_W-1:0] log_r;

  plr_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_d (
    .clk (clk),
    .en  (en),
    .x   (d_reg),
    .lg  (log_d)
  );

  plr_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_r (
    .clk (clk),
    .en  (en),
    .x   (r_reg),
    .lg  (log_r)
  );

  // Scale log ratio by the exponent, floor of divide by 4096
  logic signed [L_W-1:0] l_diff;
  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] prod_sh;
  logic signed [Y_W-1:0] y_reg;

  assign l_diff  = $signed({1'b0, log_d}) - $signed({1'b0, log_r});
  assign prod    = P_W'(l_diff) * $signed(P_W'({1'b0, curve_exponent}));
  assign prod_sh = prod >>> 12;

  always_ff @(posedge clk) begin
    if (en) y_reg <= prod_sh[Y_W-1:0];
  end

  // Integer part travels beside the exp2 chain
  logic signed [10:0] n_pipe [0:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      n_pipe[0] <= y_reg[Y_W-1:FRAC_BITS];
      for (int j = 1; j <= FRAC_BITS; j++) n_pipe[j] <= n_pipe[j-1];
    end
  end

  logic [31:0] pw;

  plr_exp2 #(.FRAC_BITS(FRAC_BITS)) u_exp (
    .clk (clk),
    .en  (en),
    .f   (y_reg[FRAC_BITS-1:0]),
    .pw  (pw)
  );

  // Scale by the target span magnitude
  logic signed [32:0] t_span;
  logic [31:0]        t_abs;
  logic [63:0]        mag;

  assign t_span = 33'(target_level) - 33'(min_level);
  assign t_abs  = t_span[32] ? 32'(-t_span) : t_span[31:0];

  always_ff @(posedge clk) begin
    if (en) mag <= 64'(t_abs) * 64'(pw);
  end

  // Apply the power-of-two shift with overflow detect and rounding
  logic signed [11:0] shift;
  logic [11:0]        sh_r;
  logic [97:0]        wide;
  logic [64:0]        rnd;
  logic [33:0]        val_next;
  logic               over_next;
  logic [33:0]        val;
  logic               over;

  assign shift = 12'(n_pipe[FRAC_BITS]) - 12'sd30;
  assign sh_r  = 12'(-shift);

  always_comb begin
    wide      = '0;
    rnd       = '0;
    val_next  = '0;
    over_next = 1'b0;
    if (!shift[11]) begin
      if (shift > 12'sd33) begin
        over_next = (mag != 64'd0);
      end else begin
        wide      = 98'(mag) << shift[5:0];
        over_next = wide > 98'(64'd1 << 33);
        val_next  = wide[33:0];
      end
    end else if (sh_r < 12'd64) begin
      rnd       = (65'(mag) + (65'd1 << (sh_r[5:0] - 6'd1))) >> sh_r[5:0];
      over_next = rnd > 65'(64'd1 << 33);
      val_next  = rnd[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val  <= val_next;
      over <= over_next;
    end
  end

  // Offset by black level, clip and select pass-through
  logic signed [35:0] res;
  logic signed [31:0] out_next;
  logic               sat_next;

  always_comb begin
    res      = t_span[32] ? 36'(min_level) - 36'(val) : 36'(min_level) + 36'(val);
    out_next = res[31:0];
    sat_next = 1'b0;
    if (pass_pipe[NST-2]) begin
      out_next = s_pipe[NST-2];
    end else if (over) begin
      out_next = t_span[32] ? plr_pkg::RES_MIN : plr_pkg::RES_MAX;
      sat_next = 1'b1;
    end else if (res > 36'(plr_pkg::RES_MAX)) begin
      out_next = plr_pkg::RES_MAX;
      sat_next = 1'b1;
    end else if (res < 36'(plr_pkg::RES_MIN)) begin
      out_next = plr_pkg::RES_MIN;
      sat_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_out <= out_next;
      saturated  <= sat_next;
    end
  end

endmodule
